/* hdl/mf3x3_pkg.sv */
// Shared types, constants and configuration codes of the 3x3 median filter.
package mf3x3_pkg;

  localparam int PIXEL_BITS     = 16;
  localparam int MAX_WIDTH      = 4096;
  localparam int COL_BITS       = $clog2(MAX_WIDTH);
  localparam int ROW_BITS       = 16;
  localparam int WIDTH_CFG_BITS = 13;
  localparam int CFG_DATA_BITS  = 16;
  localparam int CFG_IDX_BITS   = 2;
  localparam int RESET_WIDTH    = 640;
  localparam int RESET_HEIGHT   = 480;
  localparam int QUEUE_DEPTH    = 4;
  localparam int QPTR_BITS      = $clog2(QUEUE_DEPTH);

  typedef logic [PIXEL_BITS-1:0] pix_t;
  typedef logic [COL_BITS-1:0]   col_t;
  typedef logic [ROW_BITS-1:0]   row_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_ZERO_SKIP    = 2'd2
  } cfg_index_t;

  typedef struct packed {
    pix_t pixel_in;
    logic flush;
  } pixel_beat_t;

  typedef struct packed {
    pix_t pixel_out;
    logic filtered;
    logic frame_last;
  } result_beat_t;

  typedef struct packed {
    col_t wm1;
    row_t hm1;
  } geom_t;

  typedef struct packed {
    logic is_pixel;
    pix_t pixel;
    col_t addr;
    logic col_last;
    logic has_result;
    logic sel_corner;
    logic filt;
    logic last;
  } cmd_t;

endpackage

/* hdl/median_filter_3x3_top.sv */
// Top level of the streaming 3x3 median filter with configuration registers.
//
// Usage:
//   Pixel beats enter on pixel_valid/pixel_stall/pixel_beat in raster order;
//   a beat with flush set carries no pixel and, once the frame's pixels are in,
//   pushes out one pending result. Results leave on
//   result_valid/result_stall/result_beat in raster order. Each result belongs
//   to the pixel one row plus one pixel before the beat that releases it;
//   frame_width+1 flush beats drain the last results. A releasing beat's result
//   passes the command queue, b1, s1, s2, s3 and the output register.
//   Throughput is one beat per cycle while pixel_stall is low: one line buffer read and write per
//   beat and a three-stage sorting network set the pipeline. A four-entry
//   command queue holds accepted beats while result_stall is high; pixel_stall
//   rises only when that queue is full. Write frame_width, frame_height and
//   zero_skip_mode through cfg_we, cfg_index and cfg_data while the block is idle; a geometry write restarts
//   the frame. Reset loads 640 x 480, plain median, and empties the pipeline.
//   Line buffer contents are not cleared at reset.
module median_filter_3x3_top (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    pixel_valid,
  output logic                                    pixel_stall,
  input  mf3x3_pkg::pixel_beat_t                  pixel_beat,
  output logic                                    result_valid,
  input  logic                                    result_stall,
  output mf3x3_pkg::result_beat_t                 result_beat,
  input  logic                                    cfg_we,
  input  logic [mf3x3_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [mf3x3_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

  mf3x3_pkg::geom_t  geom;
  logic              zero_skip;
  logic              restart;
  logic [mf3x3_pkg::WIDTH_CFG_BITS-1:0] w_raw;
  mf3x3_pkg::col_t   wm1_new;
  mf3x3_pkg::row_t   hm1_new;
  logic              push, pop, head_valid, queue_full;
  mf3x3_pkg::cmd_t   cmd, head;

  always_comb begin
    w_raw = cfg_data[mf3x3_pkg::WIDTH_CFG_BITS-1:0];
    if (w_raw == '0) begin
      wm1_new = '0;
    end else if (w_raw > mf3x3_pkg::WIDTH_CFG_BITS'(mf3x3_pkg::MAX_WIDTH)) begin
      wm1_new = mf3x3_pkg::COL_BITS'(mf3x3_pkg::MAX_WIDTH - 1);
    end else begin
      wm1_new = mf3x3_pkg::COL_BITS'(w_raw - mf3x3_pkg::WIDTH_CFG_BITS'(1));
    end
    hm1_new = (cfg_data == '0) ? '0 : mf3x3_pkg::ROW_BITS'(cfg_data - 1'b1);
    restart = cfg_we &&
              ((cfg_index == mf3x3_pkg::CFG_FRAME_WIDTH) ||
               (cfg_index == mf3x3_pkg::CFG_FRAME_HEIGHT));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      geom.wm1  <= mf3x3_pkg::COL_BITS'(mf3x3_pkg::RESET_WIDTH - 1);
      geom.hm1  <= mf3x3_pkg::ROW_BITS'(mf3x3_pkg::RESET_HEIGHT - 1);
      zero_skip <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mf3x3_pkg::CFG_FRAME_WIDTH:  geom.wm1  <= wm1_new;
        mf3x3_pkg::CFG_FRAME_HEIGHT: geom.hm1  <= hm1_new;
        mf3x3_pkg::CFG_ZERO_SKIP:    zero_skip <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  mf3x3_front u_front (
    .clk         (clk),
    .rst         (rst),
    .pixel_valid (pixel_valid),
    .pixel_beat  (pixel_beat),
    .pixel_stall (pixel_stall),
    .geom        (geom),
    .restart     (restart),
    .queue_full  (queue_full),
    .push        (push),
    .cmd         (cmd)
  );

  mf3x3_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (cmd),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head),
    .full       (queue_full)
  );

  mf3x3_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .zero_skip    (zero_skip),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_beat  (result_beat)
  );

endmodule

/* hdl/mf3x3_ram.sv */
// Generic single-write, single-read RAM with registered read-old-data output.
module mf3x3_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(DEPTH)-1:0]   waddr,
  input  logic [WIDTH-1:0]           wdata,
  input  logic                       re,
  input  logic [$clog2(DEPTH)-1:0]   raddr,
  output logic [WIDTH-1:0]           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/mf3x3_front.sv */
// Front end: accepts beats, tracks frame position and emits commands for the back end.
module mf3x3_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     pixel_valid,
  input  mf3x3_pkg::pixel_beat_t   pixel_beat,
  output logic                     pixel_stall,
  input  mf3x3_pkg::geom_t         geom,
  input  logic                     restart,
  input  logic                     queue_full,
  output logic                     push,
  output mf3x3_pkg::cmd_t          cmd
);

  mf3x3_pkg::row_t row, row_next, er, er_next;
  mf3x3_pkg::col_t col, col_next, ec, ec_next;
  logic            in_done, in_done_next;
  logic            accept, is_flush, col_last, row_last, emit_last, enq, has_res;

  always_comb begin
    pixel_stall = queue_full;
    accept      = pixel_valid && !queue_full;
    is_flush    = pixel_beat.flush;
    col_last    = (col == geom.wm1);
    row_last    = (row == geom.hm1);
    emit_last   = (er == geom.hm1) && (ec == geom.wm1);
    enq         = is_flush ? in_done : !in_done;
    has_res     = is_flush || !((row == '0) ||
                                ((row == mf3x3_pkg::ROW_BITS'(1)) && (col == '0)));
    push        = accept && enq;

    cmd.is_pixel   = !is_flush;
    cmd.pixel      = pixel_beat.pixel_in;
    cmd.addr       = is_flush ? ec : col;
    cmd.col_last   = col_last;
    cmd.has_result = has_res;
    cmd.sel_corner = is_flush ? (er != geom.hm1) : (col == '0);
    cmd.filt       = !is_flush && (er != '0) && (er < geom.hm1) &&
                     (ec != '0) && (ec < geom.wm1);
    cmd.last       = emit_last;

    row_next     = row;
    col_next     = col;
    er_next      = er;
    ec_next      = ec;
    in_done_next = in_done;

    if (push && !is_flush) begin
      if (col_last) begin
        col_next = '0;
        row_next = row + mf3x3_pkg::ROW_BITS'(1);
        if (row_last) begin
          in_done_next = 1'b1;
        end
      end else begin
        col_next = col + mf3x3_pkg::COL_BITS'(1);
      end
    end

    if (push && has_res) begin
      if (emit_last) begin
        row_next     = '0;
        col_next     = '0;
        er_next      = '0;
        ec_next      = '0;
        in_done_next = 1'b0;
      end else if (ec == geom.wm1) begin
        ec_next = '0;
        er_next = er + mf3x3_pkg::ROW_BITS'(1);
      end else begin
        ec_next = ec + mf3x3_pkg::COL_BITS'(1);
      end
    end

    if (restart) begin
      row_next     = '0;
      col_next     = '0;
      er_next      = '0;
      ec_next      = '0;
      in_done_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row     <= '0;
      col     <= '0;
      er      <= '0;
      ec      <= '0;
      in_done <= 1'b0;
    end else begin
      row     <= row_next;
      col     <= col_next;
      er      <= er_next;
      ec      <= ec_next;
      in_done <= in_done_next;
    end
  end

endmodule

/* hdl/mf3x3_queue.sv */
// Short command queue between the front and back ends.
module mf3x3_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  mf3x3_pkg::cmd_t   push_cmd,
  input  logic              pop,
  output logic              head_valid,
  output mf3x3_pkg::cmd_t   head,
  output logic              full
);

  mf3x3_pkg::cmd_t                  entries [mf3x3_pkg::QUEUE_DEPTH];
  logic [mf3x3_pkg::QPTR_BITS-1:0]  wr_ptr, rd_ptr;
  logic [mf3x3_pkg::QPTR_BITS:0]    count;

  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];
  assign full       = (count == (mf3x3_pkg::QPTR_BITS + 1)'(mf3x3_pkg::QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + mf3x3_pkg::QPTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + mf3x3_pkg::QPTR_BITS'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + (mf3x3_pkg::QPTR_BITS + 1)'(1);
        2'b01:   count <= count - (mf3x3_pkg::QPTR_BITS + 1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

/* hdl/mf3x3_back.sv */
// Back end: line buffers, 3x3 window, pipelined median network and output register.
module mf3x3_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       head_valid,
  input  mf3x3_pkg::cmd_t            head,
  output logic                       pop,
  input  logic                       zero_skip,
  output logic                       result_valid,
  input  logic                       result_stall,
  output mf3x3_pkg::result_beat_t    result_beat
);

  typedef logic [mf3x3_pkg::PIXEL_BITS:0] key_t;

  typedef struct packed {
    mf3x3_pkg::pix_t value;
    logic            filt;
    logic            last;
  } meta_t;

  typedef struct packed {
    mf3x3_pkg::pix_t mn;
    mf3x3_pkg::pix_t md;
    mf3x3_pkg::pix_t mx;
  } trio_t;

  function automatic mf3x3_pkg::pix_t min2(input mf3x3_pkg::pix_t a, input mf3x3_pkg::pix_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic mf3x3_pkg::pix_t max2(input mf3x3_pkg::pix_t a, input mf3x3_pkg::pix_t b);
    return (a < b) ? b : a;
  endfunction

  function automatic mf3x3_pkg::pix_t med3(input mf3x3_pkg::pix_t a, input mf3x3_pkg::pix_t b,
                                           input mf3x3_pkg::pix_t c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  function automatic trio_t sort3(input mf3x3_pkg::pix_t a, input mf3x3_pkg::pix_t b,
                                  input mf3x3_pkg::pix_t c);
    mf3x3_pkg::pix_t lo1, hi1, t;
    trio_t           r;
    lo1  = min2(a, b);
    hi1  = max2(a, b);
    t    = min2(hi1, c);
    r.mx = max2(hi1, c);
    r.mn = min2(lo1, t);
    r.md = max2(lo1, t);
    return r;
  endfunction

  function automatic key_t kmin2(input key_t a, input key_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic key_t key_of(input mf3x3_pkg::pix_t v);
    return {(v == '0), v};
  endfunction

  logic            advance;
  logic            b1_valid, s1_valid, s2_valid, s3_valid;
  mf3x3_pkg::cmd_t b1;
  mf3x3_pkg::pix_t up_rd, mid_rd, up_val, corner, fwd_data, b1_value;
  logic            fwd_hit;
  mf3x3_pkg::pix_t window  [9];
  mf3x3_pkg::pix_t shifted [9];
  mf3x3_pkg::pix_t s1_win  [9];
  meta_t           s1_meta, s2_meta, s3_meta;
  trio_t           s2_trio [3];
  trio_t           trio    [3];
  key_t            s2_nz   [3];
  key_t            nz3     [3];
  mf3x3_pkg::pix_t s3_lo, s3_mi, s3_hi;
  key_t            s3_nz;
  mf3x3_pkg::pix_t med, zs_med, out_value;

  assign advance = !result_valid || !result_stall;
  assign pop     = advance && head_valid;

  mf3x3_ram #(
    .WIDTH (mf3x3_pkg::PIXEL_BITS),
    .DEPTH (mf3x3_pkg::MAX_WIDTH)
  ) u_mid_ram (
    .clk   (clk),
    .we    (pop && head.is_pixel),
    .waddr (head.addr),
    .wdata (head.pixel),
    .re    (advance),
    .raddr (head.addr),
    .rdata (mid_rd)
  );

  mf3x3_ram #(
    .WIDTH (mf3x3_pkg::PIXEL_BITS),
    .DEPTH (mf3x3_pkg::MAX_WIDTH)
  ) u_up_ram (
    .clk   (clk),
    .we    (b1_valid && b1.is_pixel),
    .waddr (b1.addr),
    .wdata (mid_rd),
    .re    (advance),
    .raddr (head.addr),
    .rdata (up_rd)
  );

  always_comb begin
    up_val = fwd_hit ? fwd_data : up_rd;
    for (int k = 0; k < 3; k++) begin
      shifted[3*k]     = window[3*k+1];
      shifted[3*k + 1] = window[3*k+2];
    end
    shifted[2] = up_val;
    shifted[5] = mid_rd;
    shifted[8] = b1.pixel;
    b1_value   = b1.sel_corner ? corner : (b1.is_pixel ? window[5] : mid_rd);

    for (int g = 0; g < 3; g++) begin
      trio[g] = sort3(s1_win[3*g], s1_win[3*g+1], s1_win[3*g+2]);
      nz3[g]  = kmin2(kmin2(key_of(s1_win[3*g]), key_of(s1_win[3*g+1])),
                      key_of(s1_win[3*g+2]));
    end

    med       = med3(s3_lo, s3_mi, s3_hi);
    zs_med    = (med != '0) ? med : s3_nz[mf3x3_pkg::PIXEL_BITS-1:0];
    out_value = s3_meta.filt ? (zero_skip ? zs_med : med) : s3_meta.value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid     <= 1'b0;
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      s3_valid     <= 1'b0;
      result_valid <= 1'b0;
      fwd_hit      <= 1'b0;
    end else if (advance) begin
      b1_valid     <= head_valid;
      fwd_hit      <= b1_valid && b1.is_pixel && (b1.addr == head.addr);
      s1_valid     <= b1_valid && b1.has_result;
      s2_valid     <= s1_valid;
      s3_valid     <= s2_valid;
      result_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      b1       <= head;
      fwd_data <= mid_rd;
      if (b1_valid && b1.is_pixel) begin
        window <= shifted;
        if (b1.col_last) begin
          corner <= mid_rd;
        end
      end
      s1_win        <= shifted;
      s1_meta.value <= b1_value;
      s1_meta.filt  <= b1.filt;
      s1_meta.last  <= b1.last;
      s2_trio       <= trio;
      s2_nz         <= nz3;
      s2_meta       <= s1_meta;
      s3_lo         <= max2(max2(s2_trio[0].mn, s2_trio[1].mn), s2_trio[2].mn);
      s3_mi         <= med3(s2_trio[0].md, s2_trio[1].md, s2_trio[2].md);
      s3_hi         <= min2(min2(s2_trio[0].mx, s2_trio[1].mx), s2_trio[2].mx);
      s3_nz         <= kmin2(kmin2(s2_nz[0], s2_nz[1]), s2_nz[2]);
      s3_meta       <= s2_meta;
      result_beat.pixel_out  <= out_value;
      result_beat.filtered   <= s3_meta.filt;
      result_beat.frame_last <= s3_meta.last;
    end
  end

endmodule

/* test/tb_median_filter_3x3_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the streaming 3x3 median filter with a bit-exact predictor.
module tb_median_filter_3x3_top;
  import mf3x3_pkg::*;

  localparam int SETTLE_CYCLES  = 12;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int LONG_HOLD      = 400;
  localparam int RANDOM_ITEMS   = 1500;
  localparam int REPORT_LIMIT   = 100;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     pixel_valid = 1'b0;
  logic                     pixel_stall;
  pixel_beat_t              pixel_beat = '0;
  logic                     result_valid;
  logic                     result_stall = 1'b0;
  result_beat_t             result_beat;
  logic                     cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  median_filter_3x3_top dut (
    .clk          (clk),
    .rst          (rst),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .pixel_beat   (pixel_beat),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_beat  (result_beat),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  pixel_beat_t  pixel_backlog[$];
  result_beat_t due_results[$];
  result_beat_t due_head;

  pix_t                      upper_line [MAX_WIDTH];
  pix_t                      middle_line [MAX_WIDTH];
  pix_t                      win_px [9];
  logic [WIDTH_CFG_BITS-1:0] m_width;
  row_t                      m_height;
  logic                      m_zskip;
  row_t                      m_row;
  col_t                      m_col;
  logic [27:0]               m_emitted;

  int unsigned items_pushed = 0;
  int unsigned items_accepted = 0;
  int unsigned regular_items = 0;
  int unsigned pixels_taken = 0;
  int unsigned flushes_taken = 0;
  int unsigned results_seen = 0;
  int unsigned medians = 0;
  int unsigned frames_done = 0;
  int unsigned cfg_writes = 0;
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  bit          zskip_setting = 1'b0;

  logic        beat_taken = 1'b0;
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;

  int unsigned hold_left = 0;
  bit          long_hold_done = 1'b0;
  int unsigned stall_mode = 0;
  int unsigned stall_mode_left = 0;
  int unsigned stall_tick = 0;

  function automatic int unsigned eff_cols(input int unsigned v);
    if (v == 0) return 1;
    if (v > MAX_WIDTH) return MAX_WIDTH;
    return v;
  endfunction

  function automatic pix_t rand_pixel();
    case ($urandom_range(0, 7))
      0, 1, 2: return '0;
      3:       return '1;
      4:       return pix_t'($urandom_range(0, 3));
      default: return pix_t'($urandom);
    endcase
  endfunction

  function automatic pix_t window_median();
    pix_t s [9];
    pix_t v;
    int   i;
    int   j;
    s = win_px;
    for (i = 1; i < 9; i++) begin
      v = s[i];
      j = i;
      while (j > 0 && s[j-1] > v) begin
        s[j] = s[j-1];
        j--;
      end
      s[j] = v;
    end
    if (m_zskip) begin
      for (i = 4; i < 9; i++)
        if (s[i] != '0) return s[i];
      return '0;
    end
    return s[4];
  endfunction

  task automatic restart_counts();
    m_row = '0;
    m_col = '0;
    m_emitted = '0;
  endtask

  task automatic filter_step(input pixel_beat_t b);
    int unsigned  w, h, total, e, er, ec, r, c;
    int           k;
    pix_t         value, up, mid, corner;
    logic         filt;
    result_beat_t res;
    w = eff_cols(m_width);
    h = (m_height == 0) ? 1 : m_height;
    total = w * h;
    e = m_emitted;
    filt = 1'b0;
    if (e >= total || m_col >= w) begin
      restart_counts();
      e = 0;
    end
    if (b.flush) begin
      if (m_row < h) return;
      er = e / w;
      ec = e % w;
      value = (er + 1 >= h) ? middle_line[ec] : upper_line[w-1];
    end else begin
      r = m_row;
      c = m_col;
      if (r >= h) return;
      up = upper_line[c];
      mid = middle_line[c];
      corner = upper_line[w-1];
      for (k = 0; k < 3; k++) begin
        win_px[k*3]   = win_px[k*3+1];
        win_px[k*3+1] = win_px[k*3+2];
      end
      win_px[2] = up;
      win_px[5] = mid;
      win_px[8] = b.pixel_in;
      upper_line[c] = mid;
      middle_line[c] = b.pixel_in;
      if (c + 1 >= w) begin
        m_col = '0;
        m_row = row_t'(r + 1);
      end else begin
        m_col = col_t'(c + 1);
      end
      if (r * w + c < w + 1) return;
      er = e / w;
      ec = e % w;
      value = (c == 0) ? corner : win_px[4];
      if (w >= 3 && h >= 3 && er >= 1 && er + 2 <= h && ec >= 1 && ec + 2 <= w) begin
        value = window_median();
        filt = 1'b1;
        medians++;
      end
    end
    res.pixel_out = value;
    res.filtered = filt;
    res.frame_last = (e + 1 == total);
    due_results.push_back(res);
    m_emitted = e + 1;
    if (res.frame_last) begin
      restart_counts();
      frames_done++;
    end
  endtask

  // accept beats and register writes, advance the predictor
  always @(posedge clk) begin
    beat_taken <= pixel_valid && !pixel_stall;
    if (rst) begin
      foreach (upper_line[i]) upper_line[i] = '0;
      foreach (middle_line[i]) middle_line[i] = '0;
      foreach (win_px[i]) win_px[i] = '0;
      m_width = WIDTH_CFG_BITS'(RESET_WIDTH);
      m_height = row_t'(RESET_HEIGHT);
      m_zskip = 1'b0;
      restart_counts();
    end else begin
      if (cfg_we) begin
        case (cfg_index_t'(cfg_index))
          CFG_FRAME_WIDTH: begin
            m_width = cfg_data[WIDTH_CFG_BITS-1:0];
            restart_counts();
          end
          CFG_FRAME_HEIGHT: begin
            m_height = cfg_data;
            restart_counts();
          end
          CFG_ZERO_SKIP: m_zskip = cfg_data[0];
          default: ;
        endcase
      end
      if (pixel_valid && !pixel_stall) begin
        items_accepted++;
        if (pixel_beat.flush) flushes_taken++;
        else pixels_taken++;
        filter_step(pixel_beat);
      end
    end
  end

  // drive the next beat in bursts with random gaps
  always @(negedge clk) begin
    if (rst) begin
      pixel_valid <= 1'b0;
    end else if (!pixel_valid || beat_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        pixel_valid <= 1'b0;
      end else if (pixel_backlog.size() > 0) begin
        pixel_beat <= pixel_backlog.pop_front();
        pixel_valid <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        pixel_valid <= 1'b0;
      end
    end
  end

  // receiver stall pattern, with one long hold while beats are still offered
  always @(negedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else if (!long_hold_done && items_accepted > 100 && pixel_backlog.size() > 20) begin
      long_hold_done = 1'b1;
      hold_left = LONG_HOLD;
      result_stall <= 1'b1;
    end else begin
      if (stall_mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_mode_left = $urandom_range(32, 400);
      end else begin
        stall_mode_left--;
      end
      stall_tick++;
      case (stall_mode)
        0:       result_stall <= 1'b0;
        1:       result_stall <= $urandom_range(0, 1);
        2:       result_stall <= ($urandom_range(0, 3) != 0);
        default: result_stall <= (stall_tick % 3 == 0);
      endcase
    end
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatches++;
    if (mismatches <= REPORT_LIMIT)
      $display("mismatch on result %0d: %s got %0h want %0h", results_seen, what, got, want);
  endtask

  // check each result beat against the oldest due result
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      results_seen++;
      if (due_results.size() == 0) begin
        report_mismatch("result with none due, pixel_out", result_beat.pixel_out, 0);
      end else begin
        due_head = due_results.pop_front();
        if (result_beat.pixel_out !== due_head.pixel_out)
          report_mismatch("pixel_out", result_beat.pixel_out, due_head.pixel_out);
        if (result_beat.filtered !== due_head.filtered)
          report_mismatch("filtered", result_beat.filtered, due_head.filtered);
        if (result_beat.frame_last !== due_head.frame_last)
          report_mismatch("frame_last", result_beat.frame_last, due_head.frame_last);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (pixel_valid && !pixel_stall) || (result_valid && !result_stall) ||
        (!pixel_valid && due_results.size() == 0)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no beat moved for %0d cycles, %0d results due",
                 idle_cycles, due_results.size());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic queue_beat(input pix_t p, input logic fl, input bit counts);
    pixel_beat_t b;
    b.pixel_in = p;
    b.flush = fl;
    pixel_backlog.push_back(b);
    items_pushed++;
    if (counts) regular_items++;
  endtask

  task automatic write_reg(input cfg_index_t idx, input int unsigned value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[CFG_DATA_BITS-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    cfg_writes++;
  endtask

  task automatic wait_idle();
    while (items_accepted != items_pushed || due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // one frame of pixels and its flushes, with optional noise or an abort
  task automatic queue_frame(input int unsigned w, input int unsigned h, input bit big,
                             output bit aborted);
    int total, n_pix, i, j, last_flush, early_at, zs_at, extra_at;
    total = w * h;
    n_pix = total;
    aborted = 1'b0;
    early_at = -1;
    zs_at = -1;
    extra_at = -1;
    if (!big) begin
      if ($urandom_range(0, 11) == 0) begin
        n_pix = $urandom_range(0, total - 1);
        aborted = 1'b1;
      end
      if ($urandom_range(0, 5) == 0) early_at = $urandom_range(0, total - 1);
      if (!aborted && total >= 2 && $urandom_range(0, 5) == 0)
        zs_at = $urandom_range(1, total - 1);
    end
    for (i = 0; i < n_pix; i++) begin
      if (i == early_at) queue_beat(pix_t'($urandom), 1'b1, 1'b0);
      if (i == zs_at) begin
        wait_idle();
        zskip_setting = !zskip_setting;
        write_reg(CFG_ZERO_SKIP, zskip_setting);
      end
      queue_beat(rand_pixel(), 1'b0, !big);
    end
    if (aborted) return;
    last_flush = (h == 1) ? w - 1 : w;
    if (!big && $urandom_range(0, 5) == 0) extra_at = $urandom_range(0, last_flush);
    for (j = 0; j <= w; j++) begin
      if (j == extra_at) queue_beat(rand_pixel(), 1'b0, 1'b0);
      queue_beat(pix_t'($urandom), 1'b1, !big);
    end
  endtask

  initial begin
    int unsigned phase;
    int unsigned w_reg, h_reg, w, h, nframes, f;
    bit          big;
    bit          aborted;
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    // 3x3 frame in zero-skip mode: early flush, mostly-zero window, extra pixel
    write_reg(CFG_FRAME_WIDTH, 3);
    write_reg(CFG_FRAME_HEIGHT, 3);
    zskip_setting = 1'b1;
    write_reg(CFG_ZERO_SKIP, zskip_setting);
    queue_beat('1, 1'b1, 1'b0);
    queue_beat('0, 1'b0, 1'b0);
    queue_beat('0, 1'b0, 1'b0);
    queue_beat('0, 1'b0, 1'b0);
    queue_beat('0, 1'b0, 1'b0);
    queue_beat('0, 1'b0, 1'b0);
    queue_beat('1, 1'b0, 1'b0);
    queue_beat('0, 1'b0, 1'b0);
    queue_beat('1, 1'b0, 1'b0);
    queue_beat('1, 1'b0, 1'b0);
    queue_beat(16'h5a5a, 1'b0, 1'b0);
    queue_beat('0, 1'b1, 1'b0);
    queue_beat('1, 1'b1, 1'b0);
    queue_beat(16'ha5a5, 1'b1, 1'b0);
    queue_beat('0, 1'b1, 1'b0);
    wait_idle();

    phase = 0;
    while (regular_items < RANDOM_ITEMS) begin
      phase++;
      big = 1'b1;
      case (phase)
        3: begin w_reg = 0;    h_reg = 65535; end
        6: begin w_reg = 4096; h_reg = 3;     end
        9: begin w_reg = 5000; h_reg = 0;     end
        default: begin
          big = 1'b0;
          if ($urandom_range(0, 7) == 0) begin
            w_reg = $urandom_range(10, 40);
            h_reg = $urandom_range(2, 4);
          end else begin
            w_reg = $urandom_range(1, 9);
            h_reg = $urandom_range(1, 7);
          end
        end
      endcase
      w = eff_cols(w_reg);
      h = (h_reg == 0) ? 1 : h_reg;
      wait_idle();
      write_reg(CFG_FRAME_WIDTH, w_reg);
      write_reg(CFG_FRAME_HEIGHT, h_reg);
      zskip_setting = $urandom_range(0, 1);
      write_reg(CFG_ZERO_SKIP, zskip_setting);
      nframes = big ? 1 : $urandom_range(1, 3);
      for (f = 0; f < nframes; f++) begin
        queue_frame(w, h, big, aborted);
        if (aborted) break;
      end
    end

    wait_idle();
    $display("covered %0d pixel and %0d flush beats, %0d results (%0d medians) in %0d frames",
             pixels_taken, flushes_taken, results_seen, medians, frames_done);
    $display("over %0d register writes, widths 0 to 5000 and heights 0 to 65535, both modes",
             cfg_writes);
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
